### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LRU page order list.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rstn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (cond)) \
    else $error("assertion failed: condition does not hold");

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");

`endif

### sv/lpol_pkg.sv
// ----------------------------------------------------------------------------
// lpol_pkg
// Types and codes shared by the LRU page order list cells and top level.
// ----------------------------------------------------------------------------
package lpol_pkg;

  // Page frame number width
  localparam int PAGE_ID_W = 20;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ACCESS = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_INSERTED    = 3'd0;
  localparam logic [2:0] STAT_MOVED       = 3'd1;
  localparam logic [2:0] STAT_NOT_TRACKED = 3'd2;
  localparam logic [2:0] STAT_EVICTED     = 3'd3;
  localparam logic [2:0] STAT_EMPTY       = 3'd4;
  localparam logic [2:0] STAT_FULL        = 3'd5;
  localparam logic [2:0] STAT_IGNORED     = 3'd6;

  // Input item
  typedef struct packed {
    logic [1:0]           op;
    logic [PAGE_ID_W-1:0] page_id;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]           status;
    logic                 victim_valid;
    logic [PAGE_ID_W-1:0] victim_page;
  } out_item_t;

  // Update control broadcast to every cell
  typedef struct packed {
    logic                 wr_en;
    logic [PAGE_ID_W-1:0] front_page;
  } cell_ctrl_t;

endpackage

### sv/lru_page_order_list_unit.sv
// ----------------------------------------------------------------------------
// lru_page_order_list_unit
// LRU page list built as a chain of cells, most recent page at cell 0.
// ----------------------------------------------------------------------------
// Steps: an accepted item is registered, then compared in all cells at once;
// the update step encodes the match, shifts the chain and registers the result
//   at out_data, holding on a stall; the next item is taken as it ends.
// Reset (rst_n low, synchronous): list empty, tracking on, no result pending.
//   Cell contents are not cleared; the entry count alone marks them valid.
`include "assert_macros.svh"

module lru_page_order_list_unit #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpol_pkg::in_item_t   in_data,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpol_pkg::out_item_t  out_data,
  // tracking enable register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                      state_r;
  logic [1:0]                      state_nxt;
  lpol_pkg::in_item_t              item_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [CNT_W-1:0]                cnt_nxt;
  logic                            trk_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  lpol_pkg::out_item_t             out_r;
  lpol_pkg::out_item_t             res;

  logic [lpol_pkg::PAGE_ID_W-1:0]  page_vec [DEPTH];
  logic [lpol_pkg::PAGE_ID_W-1:0]  tail_vec [DEPTH];
  logic [DEPTH-1:0]                hit_vec;
  logic                            hit_any;
  logic [POS_W-1:0]                hit_pos;
  logic [lpol_pkg::PAGE_ID_W-1:0]  tail_page;

  logic                            out_free;
  logic                            in_fire;
  logic                            upd_fire;
  logic                            do_move;
  logic                            do_insert;
  logic                            do_evict;
  logic [CNT_W-1:0]                limit;
  lpol_pkg::cell_ctrl_t            ctrl;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) || ((state_r == S_UPD) && out_free));
  assign in_fire   = in_valid && !in_stall;
  assign upd_fire  = (state_r == S_UPD) && out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        lpol_cell #(.DEPTH(DEPTH), .INDEX(g)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .limit    (limit),
          .count    (cnt_r),
          .cmp_page (item_r.page_id),
          .left_page('0),
          .page_o   (page_vec[g]),
          .hit_o    (hit_vec[g]),
          .tail_o   (tail_vec[g])
        );
      end else begin : g_next
        lpol_cell #(.DEPTH(DEPTH), .INDEX(g)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .limit    (limit),
          .count    (cnt_r),
          .cmp_page (item_r.page_id),
          .left_page(page_vec[g-1]),
          .page_o   (page_vec[g]),
          .hit_o    (hit_vec[g]),
          .tail_o   (tail_vec[g])
        );
      end
    end
  endgenerate

  // One-hot match to position, tail page select
  always_comb begin
    hit_pos   = '0;
    tail_page = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_pos   = hit_pos | (hit_vec[i] ? POS_W'(i) : '0);
      tail_page = tail_page | tail_vec[i];
    end
  end

  assign hit_any = |hit_vec;

  // Operation decode and result
  always_comb begin
    do_move   = 1'b0;
    do_insert = 1'b0;
    do_evict  = 1'b0;
    res.status       = lpol_pkg::STAT_IGNORED;
    res.victim_valid = 1'b0;
    res.victim_page  = '0;
    unique case (item_r.op)
      lpol_pkg::OP_INSERT: begin
        if (hit_any) begin
          if (trk_r) begin
            do_move    = 1'b1;
            res.status = lpol_pkg::STAT_MOVED;
          end
        end else if (cnt_r == CNT_W'(DEPTH)) begin
          res.status = lpol_pkg::STAT_FULL;
        end else begin
          do_insert  = 1'b1;
          res.status = lpol_pkg::STAT_INSERTED;
        end
      end
      lpol_pkg::OP_ACCESS: begin
        if (trk_r) begin
          if (hit_any) begin
            do_move    = 1'b1;
            res.status = lpol_pkg::STAT_MOVED;
          end else begin
            res.status = lpol_pkg::STAT_NOT_TRACKED;
          end
        end
      end
      lpol_pkg::OP_EVICT: begin
        if (cnt_r == '0) begin
          res.status = lpol_pkg::STAT_EMPTY;
        end else begin
          do_evict         = 1'b1;
          res.status       = lpol_pkg::STAT_EVICTED;
          res.victim_valid = 1'b1;
          res.victim_page  = tail_page;
        end
      end
      default: begin
        res.status = lpol_pkg::STAT_IGNORED;
      end
    endcase
  end

  // Chain shift control: cells 1..limit take their neighbor, cell 0 the page
  assign limit = do_move ? CNT_W'(hit_pos) : cnt_r;
  assign ctrl  = {upd_fire && (do_move || do_insert), item_r.page_id};

  // Next state, count and output valid
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_fire ? S_CMP : S_IDLE;
          if (do_insert) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (do_evict) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      trk_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        trk_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (upd_fire) begin
      out_r <= res;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_hit_unique, clk, rst_n, state_r == S_UPD, $onehot0(hit_vec))
  `ASSERT_IMPLY(a_no_accept_cmp, clk, rst_n, state_r == S_CMP, in_stall)
  `ASSERT_IMPLY(a_victim_flag, clk, rst_n, out_valid_r, (out_r.status == lpol_pkg::STAT_EVICTED) == out_r.victim_valid)
  `ASSERT_NEXT(a_cmp_to_upd, clk, rst_n, state_r == S_CMP, state_r == S_UPD)

endmodule

### sv/lpol_cell.sv
// ----------------------------------------------------------------------------
// lpol_cell
// One slot of the recency chain: holds a page, compares it with the looked-up
// page, flags itself as tail, shifts in its left neighbor (head: front page).
// ----------------------------------------------------------------------------
module lpol_cell #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  lpol_pkg::cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]              limit,
  input  logic [CNT_W-1:0]              count,
  input  logic [lpol_pkg::PAGE_ID_W-1:0] cmp_page,
  input  logic [lpol_pkg::PAGE_ID_W-1:0] left_page,
  output logic [lpol_pkg::PAGE_ID_W-1:0] page_o,
  output logic                          hit_o,
  output logic [lpol_pkg::PAGE_ID_W-1:0] tail_o
);

  logic [lpol_pkg::PAGE_ID_W-1:0] page_r;
  logic [lpol_pkg::PAGE_ID_W-1:0] page_nxt;
  logic                           hit_r;
  logic [lpol_pkg::PAGE_ID_W-1:0] tail_r;
  logic                           occupied;
  logic                           is_tail;
  logic                           shift_en;

  assign occupied = CNT_W'(INDEX) < count;
  assign is_tail  = CNT_W'(INDEX + 1) == count;
  assign shift_en = ctrl.wr_en && (CNT_W'(INDEX) <= limit);

  // Head cell takes the new front page, others take the left neighbor
  generate
    if (INDEX == 0) begin : g_head
      assign page_nxt = ctrl.front_page;
    end else begin : g_body
      assign page_nxt = left_page;
    end
  endgenerate

  // Stored page, no reset: entries beyond the count are never read
  always_ff @(posedge clk) begin
    if (shift_en) begin
      page_r <= page_nxt;
    end
  end

  // Match and tail flags, refreshed every cycle
  always_ff @(posedge clk) begin
    hit_r  <= occupied && (page_r == cmp_page);
    tail_r <= is_tail ? page_r : '0;
  end

  assign page_o = page_r;
  assign hit_o  = hit_r;
  assign tail_o = tail_r;

endmodule

### sim/lru_page_order_list_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_page_order_list_unit_tb
// Self-checking bench for the LRU page list. A short table of directed items
// covers empty, full, duplicate and tracking-off cases. Random insert, access
// and evict bursts then drive the list between empty and full under changing
// idle and stall patterns. Every result is checked against the directed row's
// expected value or a local model of the page order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_order_list_unit_tb;

  localparam int LIST_DEPTH = 16;
  localparam int PAGE_W = lpol_pkg::PAGE_ID_W;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES = 5;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;

  // One directed table row; reps > 1 issues the row reps times, page_id + r on issue r
  typedef struct {
    lpol_pkg::in_item_t  item;
    int unsigned         reps;
    bit                  trk;
    bit                  fixed;
    lpol_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lpol_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lpol_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  // Model of the list: entry 0 most recent
  logic [PAGE_W-1:0] lru_pages [LIST_DEPTH];
  int                lru_count = 0;
  bit                lru_tracking = 1'b1;

  lpol_pkg::out_item_t pending_results_q [$];
  dir_row_t            dir_q [$];
  int                  mismatch_cnt = 0;
  int                  send_pct = 0;
  int                  recv_pct = 0;
  bit                  hold_req = 1'b0;
  bit                  hold_done = 1'b0;
  logic [PAGE_W-1:0]   page_pool_base = '0;

  lru_page_order_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shift entries 0..n-1 down one place and put page at the front
  function automatic void push_front(int n, logic [PAGE_W-1:0] page);
    for (int i = n; i > 0; i--) begin
      if (i < LIST_DEPTH) lru_pages[i] = lru_pages[i-1];
    end
    lru_pages[0] = page;
  endfunction

  // Access of a page at position pos (-1 when not tracked)
  function automatic logic [2:0] touch_page(int pos, logic [PAGE_W-1:0] page);
    if (!lru_tracking) return lpol_pkg::STAT_IGNORED;
    if (pos < 0) return lpol_pkg::STAT_NOT_TRACKED;
    push_front(pos, page);
    return lpol_pkg::STAT_MOVED;
  endfunction

  // Apply one item to the model and return the result it gives
  function automatic lpol_pkg::out_item_t predict_lru_step(lpol_pkg::in_item_t it);
    lpol_pkg::out_item_t r;
    int                  pos;
    r = '0;
    r.status = lpol_pkg::STAT_IGNORED;
    pos = -1;
    for (int i = 0; i < lru_count; i++) begin
      if (pos < 0 && lru_pages[i] == it.page_id) pos = i;
    end
    case (it.op)
      lpol_pkg::OP_INSERT: begin
        if (pos >= 0) begin
          r.status = touch_page(pos, it.page_id);
        end else if (lru_count >= LIST_DEPTH) begin
          r.status = lpol_pkg::STAT_FULL;
        end else begin
          push_front(lru_count, it.page_id);
          lru_count++;
          r.status = lpol_pkg::STAT_INSERTED;
        end
      end
      lpol_pkg::OP_ACCESS: r.status = touch_page(pos, it.page_id);
      lpol_pkg::OP_EVICT: begin
        if (lru_count == 0) begin
          r.status = lpol_pkg::STAT_EMPTY;
        end else begin
          lru_count--;
          r.status = lpol_pkg::STAT_EVICTED;
          r.victim_valid = 1'b1;
          r.victim_page = lru_pages[lru_count];
        end
      end
      default: r.status = lpol_pkg::STAT_IGNORED;
    endcase
    return r;
  endfunction

  // Random item: fill bursts lean to inserts, drain bursts to evicts
  function automatic lpol_pkg::in_item_t rand_item(bit fill_bias);
    lpol_pkg::in_item_t it;
    int                 roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 70) it.page_id = page_pool_base + PAGE_W'($urandom_range(23));
    else it.page_id = PAGE_W'($urandom);
    if (roll < 5) begin
      it.op = lpol_pkg::OP_NONE;
    end else if (roll < (fill_bias ? 60 : 25)) begin
      it.op = lpol_pkg::OP_INSERT;
      if (lru_count > 0 && $urandom_range(99) < 20)
        it.page_id = lru_pages[$urandom_range(lru_count - 1)];
    end else if (roll < (fill_bias ? 85 : 50)) begin
      it.op = lpol_pkg::OP_ACCESS;
      if (lru_count > 0 && $urandom_range(99) < 65)
        it.page_id = lru_pages[$urandom_range(lru_count - 1)];
    end else begin
      it.op = lpol_pkg::OP_EVICT;
    end
    return it;
  endfunction

  task automatic add_row(logic [1:0] op, logic [PAGE_W-1:0] page, int unsigned reps,
                         bit trk, bit fixed, logic [2:0] status, logic vvalid,
                         logic [PAGE_W-1:0] vpage);
    dir_row_t row;
    row.item.op = op;
    row.item.page_id = page;
    row.reps = reps;
    row.trk = trk;
    row.fixed = fixed;
    row.want.status = status;
    row.want.victim_valid = vvalid;
    row.want.victim_page = vpage;
    dir_q.push_back(row);
  endtask

  // Offer one item after a random gap; record its result once accepted
  task automatic send_item(lpol_pkg::in_item_t it, bit fixed, lpol_pkg::out_item_t want);
    lpol_pkg::out_item_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pred = predict_lru_step(it);
    pending_results_q.push_back(fixed ? want : pred);
  endtask

  // Write the tracking register once the list has gone quiet
  task automatic set_tracking(bit on);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lru_tracking = on;
  endtask

  // Receiver stall, with one long hold when asked
  always @(posedge clk) begin
    int hold_left;
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    lpol_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] unexpected result: status=%0d vv=%0b vpage=%h", $realtime,
                   out_data.status, out_data.victim_valid, out_data.victim_page);
      end else begin
        want = pending_results_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.victim_valid !== want.victim_valid ||
            out_data.victim_page !== want.victim_page) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] mismatch: exp st=%0d vv=%0b vp=%h, got st=%0d vv=%0b vp=%h",
                     $realtime, want.status, want.victim_valid, want.victim_page,
                     out_data.status, out_data.victim_valid, out_data.victim_page);
        end
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL lru_page_order_list_unit");
    $finish;
  end

  initial begin
    lpol_pkg::in_item_t  it;
    lpol_pkg::out_item_t none;
    dir_row_t            row;
    bit                  fill_bias;
    int                  phase_send [NUM_PHASES];
    int                  phase_recv [NUM_PHASES];
    bit                  phase_trk [NUM_PHASES];

    none = '0;
    phase_send = '{0, 47, 0, 31, 0};
    phase_recv = '{0, 0, 47, 31, 0};
    phase_trk  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    // Directed cases: empty, untracked, duplicates, op 3, full, tracking off
    add_row(lpol_pkg::OP_EVICT,  20'h00000, 1,  1, 1, lpol_pkg::STAT_EMPTY,  1'b0, 20'h0);
    add_row(lpol_pkg::OP_ACCESS, 20'h00005, 1,  1, 1, lpol_pkg::STAT_NOT_TRACKED, 1'b0,
            20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'h00000, 1,  1, 1, lpol_pkg::STAT_INSERTED, 1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'hFFFFF, 1,  1, 1, lpol_pkg::STAT_INSERTED, 1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'h00000, 1,  1, 1, lpol_pkg::STAT_MOVED,    1'b0, 20'h0);
    add_row(lpol_pkg::OP_NONE,   20'hAAAAA, 1,  1, 1, lpol_pkg::STAT_IGNORED,  1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'h00100, 14, 1, 0, lpol_pkg::STAT_INSERTED, 1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'h55555, 1,  1, 1, lpol_pkg::STAT_FULL,     1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'h00103, 1,  1, 1, lpol_pkg::STAT_MOVED,    1'b0, 20'h0);
    add_row(lpol_pkg::OP_ACCESS, 20'h00000, 1,  0, 1, lpol_pkg::STAT_IGNORED,  1'b0, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'hFFFFF, 1,  0, 1, lpol_pkg::STAT_IGNORED,  1'b0, 20'h0);
    add_row(lpol_pkg::OP_EVICT,  20'h00000, 1,  0, 0, lpol_pkg::STAT_EVICTED,  1'b1, 20'h0);
    add_row(lpol_pkg::OP_INSERT, 20'hAAAAA, 1,  0, 1, lpol_pkg::STAT_INSERTED, 1'b0, 20'h0);
    add_row(lpol_pkg::OP_ACCESS, 20'hAAAAA, 1,  1, 1, lpol_pkg::STAT_MOVED,    1'b0, 20'h0);
    add_row(lpol_pkg::OP_EVICT,  20'h00000, 1,  1, 0, lpol_pkg::STAT_EVICTED,  1'b1, 20'h0);

    // Reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table walk
    foreach (dir_q[i]) begin
      row = dir_q[i];
      if (row.trk != lru_tracking) set_tracking(row.trk);
      for (int unsigned r = 0; r < row.reps; r++) begin
        it = row.item;
        it.page_id = row.item.page_id + PAGE_W'(r);
        send_item(it, row.fixed, row.want);
      end
    end

    // Random phases under different idle patterns; the last one holds the
    // receiver off for a long stretch so the list backs up into its input
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_tracking(phase_trk[p]);
      send_pct = phase_send[p];
      recv_pct = phase_recv[p];
      page_pool_base = PAGE_W'($urandom);
      if (p == NUM_PHASES - 1) hold_req = 1'b1;
      fill_bias = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 24 == 0) fill_bias = ($urandom_range(1) == 1) ? ~fill_bias : fill_bias;
        if (n % 48 == 0) fill_bias = 1'b1;
        send_item(rand_item(fill_bias), 1'b0, none);
      end
    end

    // Drain
    in_valid <= 1'b0;
    recv_pct = 0;
    do @(posedge clk); while (pending_results_q.size() != 0);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    if (mismatch_cnt == 0 && pending_results_q.size() == 0) begin
      $display("PASS lru_page_order_list_unit");
    end else begin
      $display("FAIL lru_page_order_list_unit");
    end
    $finish;
  end

endmodule

### lru_page_order_list_unit.f
+incdir+sv
sv/lpol_pkg.sv
sv/lpol_cell.sv
sv/lru_page_order_list_unit.sv
sim/lru_page_order_list_unit_tb.sv
